@@ rtl/core/q8_block_dequant_tile_reorder_defines.svh @@
// Assertion macros shared by the block dequantizer RTL.
// Used by: q8bdq_fifo.sv, q8bdq_back.sv. No other dependencies.
`ifndef Q8_BLOCK_DEQUANT_TILE_REORDER_DEFINES_SVH
`define Q8_BLOCK_DEQUANT_TILE_REORDER_DEFINES_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define Q8BDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Concurrent check on clk_i that also holds during reset.
`define Q8BDQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("%m: check failed");

`endif

@@ rtl/core/q8bdq_pkg.sv @@
// Constants, types and helpers for the Q8 block dequantizer with B-tile reorder.
// No dependencies.
`default_nettype none
package q8bdq_pkg;

  localparam int OutputRows   = 16;
  localparam int ReductionLen = 64;
  localparam int TileK        = 8;
  localparam int TileN        = 8;

  localparam int BlkBytes   = 34;
  localparam int BlkWeights = 32;
  localparam int BlksPerRow = ReductionLen / BlkWeights;
  localparam int NTiles     = OutputRows / TileN;

  localparam int InBlkW = $clog2(BlkBytes);
  localparam int BlkW   = $clog2(BlksPerRow + 1);
  localparam int KqW    = $clog2(ReductionLen / TileK + 1);
  localparam int KrW    = $clog2(TileK + 1);
  localparam int RqW    = $clog2(OutputRows / TileN + 1);
  localparam int RrW    = $clog2(TileN + 1);

  localparam int LastRowQ = (OutputRows - 1) / TileN;
  localparam int LastRowR = (OutputRows - 1) % TileN;

  localparam int IdxW      = 10;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // Position of a byte inside a block
  localparam logic [InBlkW-1:0] PosScaleLo = InBlkW'(0);
  localparam logic [InBlkW-1:0] PosScaleHi = InBlkW'(1);
  localparam logic [InBlkW-1:0] PosLast    = InBlkW'(BlkBytes - 1);

  // Scale classes carried to the back end
  typedef enum logic [1:0] {
    SC_FINITE = 2'd0,
    SC_INF    = 2'd1,
    SC_NAN    = 2'd2
  } scale_class_e;

  // One weight request queued between front and back
  typedef struct packed {
    logic [7:0]      wbyte;
    logic            sgn;
    logic [7:0]      expo;
    logic [9:0]      frac;
    logic [IdxW-1:0] dest;
    logic            last;
  } item_t;

  localparam logic [15:0] Bf16QNan  = 16'h7fc0;
  localparam logic [15:0] Bf16Quiet = 16'h0040;
  localparam logic [7:0]  ExpMax    = 8'hff;

endpackage
`default_nettype wire

@@ rtl/core/q8bdq_front.sv @@
// Front end: tracks the byte position, widens the fp16 block scale and emits
// one queued request per weight byte with its B-tile index. Uses q8bdq_pkg.
`default_nettype none
module q8bdq_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      byte_i,
  output q8bdq_pkg::item_t     item_o,
  output logic                 push_o
);

  logic [q8bdq_pkg::InBlkW-1:0] inblk_q, inblk_d;
  logic [q8bdq_pkg::BlkW-1:0]   blk_q, blk_d;
  logic [q8bdq_pkg::KqW-1:0]    kq_q, kq_d;
  logic [q8bdq_pkg::KrW-1:0]    kr_q, kr_d;
  logic [q8bdq_pkg::RqW-1:0]    rq_q, rq_d;
  logic [q8bdq_pkg::RrW-1:0]    rr_q, rr_d;
  logic [7:0]                   lo_q;
  logic                         sgn_q;
  logic [7:0]                   exp_q;
  logic [9:0]                   frac_q;

  logic        is_weight, blk_end, row_end, tile_end;
  logic [15:0] half;
  logic [4:0]  h_exp;
  logic [9:0]  h_frac;
  logic [3:0]  lead;
  logic [7:0]  cv_exp;
  logic [9:0]  cv_frac;
  logic [31:0] dest_full;

  assign is_weight = (inblk_q != q8bdq_pkg::PosScaleLo) && (inblk_q != q8bdq_pkg::PosScaleHi);
  assign blk_end   = (inblk_q == q8bdq_pkg::PosLast);
  assign row_end   = blk_end && (blk_q == q8bdq_pkg::BlkW'(q8bdq_pkg::BlksPerRow - 1));
  assign tile_end  = row_end && (rq_q == q8bdq_pkg::RqW'(q8bdq_pkg::LastRowQ))
                     && (rr_q == q8bdq_pkg::RrW'(q8bdq_pkg::LastRowR));

  // fp16 to fp32 exponent and fraction; subnormals normalized
  assign half   = {byte_i, lo_q};
  assign h_exp  = half[14:10];
  assign h_frac = half[9:0];

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_frac[i]) begin
        lead = 4'(i);
      end
    end
  end

  always_comb begin
    cv_exp  = 8'(h_exp) + 8'd112;
    cv_frac = h_frac;
    if (h_exp == 5'd0) begin
      if (h_frac == 10'd0) begin
        cv_exp = 8'd0;
      end else begin
        cv_exp  = 8'd103 + 8'(lead);
        cv_frac = h_frac << (4'd10 - lead);
      end
    end else if (h_exp == 5'h1f) begin
      cv_exp = q8bdq_pkg::ExpMax;
    end
  end

  assign dest_full = (32'(kq_q) * 32'(q8bdq_pkg::NTiles) + 32'(rq_q))
                       * 32'(q8bdq_pkg::TileK * q8bdq_pkg::TileN)
                     + 32'(kr_q) * 32'(q8bdq_pkg::TileN) + 32'(rr_q);

  always_comb begin
    inblk_d = blk_end ? '0 : inblk_q + 1'b1;
    blk_d   = blk_q;
    kq_d    = kq_q;
    kr_d    = kr_q;
    rq_d    = rq_q;
    rr_d    = rr_q;
    if (blk_end) begin
      blk_d = row_end ? '0 : blk_q + 1'b1;
    end
    if (is_weight) begin
      if (row_end) begin
        kq_d = '0;
        kr_d = '0;
        if (tile_end) begin
          rq_d = '0;
          rr_d = '0;
        end else if (rr_q == q8bdq_pkg::RrW'(q8bdq_pkg::TileN - 1)) begin
          rr_d = '0;
          rq_d = rq_q + 1'b1;
        end else begin
          rr_d = rr_q + 1'b1;
        end
      end else if (kr_q == q8bdq_pkg::KrW'(q8bdq_pkg::TileK - 1)) begin
        kr_d = '0;
        kq_d = kq_q + 1'b1;
      end else begin
        kr_d = kr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inblk_q <= '0;
      blk_q   <= '0;
      kq_q    <= '0;
      kr_q    <= '0;
      rq_q    <= '0;
      rr_q    <= '0;
      lo_q    <= '0;
      sgn_q   <= 1'b0;
      exp_q   <= '0;
      frac_q  <= '0;
    end else if (accept_i) begin
      inblk_q <= inblk_d;
      blk_q   <= blk_d;
      kq_q    <= kq_d;
      kr_q    <= kr_d;
      rq_q    <= rq_d;
      rr_q    <= rr_d;
      if (inblk_q == q8bdq_pkg::PosScaleLo) begin
        lo_q <= byte_i;
      end
      if (inblk_q == q8bdq_pkg::PosScaleHi) begin
        sgn_q  <= half[15];
        exp_q  <= cv_exp;
        frac_q <= cv_frac;
      end
    end
  end

  assign push_o       = accept_i && is_weight;
  assign item_o.wbyte = byte_i;
  assign item_o.sgn   = sgn_q;
  assign item_o.expo  = exp_q;
  assign item_o.frac  = frac_q;
  assign item_o.dest  = dest_full[q8bdq_pkg::IdxW-1:0];
  assign item_o.last  = tile_end;

endmodule
`default_nettype wire

@@ rtl/core/q8bdq_fifo.sv @@
// Short request queue between front and back end, flip-flop storage.
// Uses q8bdq_pkg and the assertion macros header.
`default_nettype none
`include "q8_block_dequant_tile_reorder_defines.svh"
module q8bdq_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire q8bdq_pkg::item_t item_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output q8bdq_pkg::item_t      item_o
);

  q8bdq_pkg::item_t               mem_q [q8bdq_pkg::FifoDepth];
  logic [q8bdq_pkg::PtrW-1:0]     wr_q, rd_q;
  logic [q8bdq_pkg::CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == q8bdq_pkg::CntW'(q8bdq_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == q8bdq_pkg::PtrW'(q8bdq_pkg::FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == q8bdq_pkg::PtrW'(q8bdq_pkg::FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  `Q8BDQ_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> cnt_q == '0)
  `Q8BDQ_ASSERT(a_cnt_bound, cnt_q <= q8bdq_pkg::CntW'(q8bdq_pkg::FifoDepth))
  `Q8BDQ_ASSERT(a_no_pop_empty, pop_i |-> cnt_q != '0)
  `Q8BDQ_ASSERT(a_no_push_full, push_i |-> !full_o)

endmodule
`default_nettype wire

@@ rtl/core/q8bdq_back.sv @@
// Back end: multiplies scale by int8 weight, normalizes and rounds to bf16.
// Two stages with per-stage stall. Uses q8bdq_pkg and the assertion macros header.
`default_nettype none
`include "q8_block_dequant_tile_reorder_defines.svh"
module q8bdq_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire q8bdq_pkg::item_t           item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [15:0]                     bf16_o,
  output logic [q8bdq_pkg::IdxW-1:0]      dest_o,
  output logic                            last_o
);

  // stage 1
  logic                          v1_q;
  q8bdq_pkg::scale_class_e       cls_q;
  logic                          sgn_q;
  logic [7:0]                    exp_q;
  logic [15:0]                   nan_q;
  logic                          wzero_q;
  logic [18:0]                   prod_q;
  logic [q8bdq_pkg::IdxW-1:0]    dest1_q;
  logic                          last1_q;
  // stage 2
  logic                          v2_q;
  logic [15:0]                   bf_q;
  logic [q8bdq_pkg::IdxW-1:0]    dest2_q;
  logic                          last2_q;

  logic                    ld1, ld2;
  logic                    wneg;
  logic [7:0]              wmag;
  logic [10:0]             mant;
  q8bdq_pkg::scale_class_e cls_d;
  logic [2:0]              lead;
  logic [18:0]             pn;
  logic [31:0]             pb, pr;
  logic [15:0]             bf_d;

  assign ld2   = !v2_q || out_ready_i;
  assign ld1   = !v1_q || ld2;
  assign pop_o = in_valid_i && ld1;

  assign wneg = item_i.wbyte[7];
  assign wmag = wneg ? 8'(-item_i.wbyte) : item_i.wbyte;
  assign mant = (item_i.expo == 8'd0) ? 11'd0 : {1'b1, item_i.frac};

  always_comb begin
    cls_d = q8bdq_pkg::SC_FINITE;
    if (item_i.expo == q8bdq_pkg::ExpMax) begin
      cls_d = (item_i.frac != 10'd0) ? q8bdq_pkg::SC_NAN : q8bdq_pkg::SC_INF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cls_q   <= cls_d;
      sgn_q   <= item_i.sgn ^ wneg;
      exp_q   <= item_i.expo;
      nan_q   <= {item_i.sgn, item_i.expo, item_i.frac[9:3]} | q8bdq_pkg::Bf16Quiet;
      wzero_q <= (item_i.wbyte == 8'd0);
      prod_q  <= 19'(mant) * 19'(wmag);
      dest1_q <= item_i.dest;
      last1_q <= item_i.last;
    end
  end

  // Leading one sits at bit 10..17 for a nonzero product
  always_comb begin
    lead = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (prod_q[10 + i]) begin
        lead = 3'(i);
      end
    end
  end

  assign pn = prod_q << (3'd7 - lead);
  assign pb = (prod_q == 19'd0) ? {sgn_q, 31'd0}
            : {sgn_q, exp_q + 8'(lead), pn[16:0], 6'd0};
  assign pr = pb + 32'h7fff + 32'(pb[16]);

  always_comb begin
    case (cls_q)
      q8bdq_pkg::SC_NAN: bf_d = nan_q;
      q8bdq_pkg::SC_INF: bf_d = wzero_q ? q8bdq_pkg::Bf16QNan
                                        : {sgn_q, q8bdq_pkg::ExpMax, 7'd0};
      default:           bf_d = pr[31:16];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && ld2) begin
      bf_q    <= bf_d;
      dest2_q <= dest1_q;
      last2_q <= last1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
    end
  end

  assign out_valid_o = v2_q;
  assign bf16_o      = bf_q;
  assign dest_o      = dest2_q;
  assign last_o      = last2_q;

  `Q8BDQ_ASSERT(a_s1_hold, v1_q && !ld2 |=> v1_q)
  `Q8BDQ_ASSERT(a_pop_room, pop_o |-> !v1_q || ld2)
  `Q8BDQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(bf16_o))

endmodule
`default_nettype wire

@@ rtl/core/q8_block_dequant_tile_reorder.sv @@
// Top level of the Q8 block dequantizer with B-tile reorder.
// Instantiates q8bdq_front, q8bdq_fifo and q8bdq_back; uses q8bdq_pkg.
//
//   channel   dir  handshake                tdata / tuser / tlast
//   s_axis    in   s_axis_tvalid/tready     [7:0] packed_byte
//   m_axis    out  m_axis_tvalid/tready     [15:0] weight_bf16, [25:16] dest_index;
//                                           tlast = tile_last
//
// One byte is taken per cycle when the request queue has room. Scale bytes
// yield no result; each weight byte yields one result, presented on m_axis
// after the queue and the two-stage multiply/round pipe of the back end, at
// one result per cycle while m_axis_tready is high. Reset clears the byte
// position and the block scale and empties the queue and pipe. Output stalls
// back up through the pipe into the four-entry queue, then to s_axis_tready.
`default_nettype none
module q8_block_dequant_tile_reorder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] packed_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] weight_bf16, [25:16] dest_index, rest 0
  output logic             m_axis_tlast    // tile_last
);

  q8bdq_pkg::item_t             push_item, pop_item;
  logic                         push, full, q_valid, pop;
  logic                         accept;
  logic [15:0]                  bf16;
  logic [q8bdq_pkg::IdxW-1:0]   dest;

  // Take a byte whenever the queue has room; scale bytes never push.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  q8bdq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .item_o   (push_item),
    .push_o   (push)
  );

  q8bdq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (pop_item)
  );

  q8bdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .bf16_o      (bf16),
    .dest_o      (dest),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, dest, bf16};

endmodule
`default_nettype wire
